// File: design/rrp_pkg.sv
`default_nettype none

package rrp_pkg;

    // Sizing of the message offset counter and of the decimal numbers.
    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int LENGTH_BITS       = 16;
    localparam int OFFSET_W          = $clog2(MAX_MESSAGE_BYTES);

    // Port widths fixed by the interface.
    localparam int INDEX_W  = 2;
    localparam int START_W  = 12;
    localparam int ELEN_W   = 16;

    // Protocol characters.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Array count for which a value element follows the key.
    localparam logic [LENGTH_BITS-1:0] COUNT_WITH_VALUE = LENGTH_BITS'(3);

    // Element index codes.
    localparam logic [INDEX_W-1:0] ELEM_CMD   = 2'd0;
    localparam logic [INDEX_W-1:0] ELEM_KEY   = 2'd1;
    localparam logic [INDEX_W-1:0] ELEM_VALUE = 2'd2;

    // Status codes.
    localparam logic STATUS_FOUND      = 1'b0;
    localparam logic STATUS_NO_DOLLAR  = 1'b1;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_SEPA,
        PH_LEN,
        PH_SEPB,
        PH_DATA,
        PH_DONE
    } phase_t;

    // One result transaction.
    typedef struct packed {
        logic [INDEX_W-1:0]     idx;
        logic [OFFSET_W-1:0]    off;
        logic [LENGTH_BITS-1:0] len;
        logic                   status;
        logic                   last;
    } result_t;

    // Decimal accumulate: acc * 10 + digit, saturated to all ones.
    function automatic logic [LENGTH_BITS-1:0] acc_digit(
        input logic [LENGTH_BITS-1:0] acc,
        input logic [3:0]             digit
    );
        logic [LENGTH_BITS+3:0] wide;
        logic [LENGTH_BITS+3:0] ext;
        ext  = {4'b0000, acc};
        wide = (ext << 3) + (ext << 1) + {{LENGTH_BITS{1'b0}}, digit};
        if (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000)
            return {LENGTH_BITS{1'b1}};
        else
            return wide[LENGTH_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/resp_request_parser_core.sv
// Output: a result is registered and presented on the output in the cycle after the byte that causes it
// is accepted.
// Throughput: one byte per clock while out_ready is high; the parser state is updated in the
// accept cycle, and a result that waits for out_ready holds off the next byte.
// Reset: rst_n clears the parser to waiting for the array marker and empties the
// result register.
`default_nettype none

module resp_request_parser_core
    import rrp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          data_byte,
    input  wire logic                first_of_message,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [INDEX_W-1:0]       element_index,
    output logic [START_W-1:0]       start_offset,
    output logic [ELEN_W-1:0]        element_length,
    output logic                     status,
    output logic                     last
);

    // Parser state.
    phase_t                  phase_reg, phase_next;
    logic [INDEX_W-1:0]      elem_reg, elem_next;
    logic [LENGTH_BITS-1:0]  count_reg, count_next;
    logic [LENGTH_BITS-1:0]  acc_reg, acc_next;
    logic [OFFSET_W-1:0]     offset_reg, offset_next;
    logic [LENGTH_BITS-1:0]  remain_reg, remain_next;

    // Result register.
    logic                    out_valid_reg;
    result_t                 result_reg;

    // Working values for the current byte.
    logic                    accept;
    logic                    is_digit;
    logic                    is_crlf;
    logic [3:0]              digit_val;
    phase_t                  cur_phase;
    phase_t                  eval_phase;
    logic [INDEX_W-1:0]      cur_elem;
    logic [LENGTH_BITS-1:0]  cur_count;
    logic [LENGTH_BITS-1:0]  cur_acc;
    logic [OFFSET_W-1:0]     cur_offset;
    logic [LENGTH_BITS-1:0]  eval_remain;
    logic                    is_last_elem;
    logic                    res_valid;
    result_t                 res;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // Byte classification.
    assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_crlf   = (data_byte == CH_CR) || (data_byte == CH_LF);
    assign digit_val = 4'(data_byte - CH_ZERO);

    // A new message starts from the reset state.
    assign cur_phase  = first_of_message ? PH_WAIT : phase_reg;
    assign cur_elem   = first_of_message ? ELEM_CMD : elem_reg;
    assign cur_count  = first_of_message ? '0 : count_reg;
    assign cur_acc    = first_of_message ? '0 : acc_reg;
    assign cur_offset = first_of_message ? '0 : offset_reg;

    // The end of a number hands the byte on to the separator phase that follows it.
    always_comb
    begin
        eval_phase  = cur_phase;
        eval_remain = first_of_message ? '0 : remain_reg;
        if (cur_phase == PH_COUNT && !is_digit)
        begin
            eval_phase = PH_SEPA;
        end
        else if (cur_phase == PH_LEN && !is_digit)
        begin
            eval_phase  = PH_SEPB;
            eval_remain = cur_acc;
        end
    end

    // The key is last unless the array count announces a value.
    assign is_last_elem = (cur_elem >= ELEM_VALUE) ||
                          (cur_elem == ELEM_KEY && cur_count != COUNT_WITH_VALUE);

    // Next-state logic.
    always_comb
    begin
        phase_next  = eval_phase;
        elem_next   = cur_elem;
        count_next  = cur_count;
        acc_next    = cur_acc;
        remain_next = eval_remain;
        if (cur_phase == PH_COUNT && !is_digit)
        begin
            count_next = cur_acc;
        end
        if (cur_offset < OFFSET_W'(MAX_MESSAGE_BYTES - 1))
            offset_next = cur_offset + 1'b1;
        else
            offset_next = cur_offset;

        unique case (eval_phase)
            PH_WAIT:
            begin
                if (data_byte == CH_STAR)
                begin
                    phase_next = PH_COUNT;
                    acc_next   = '0;
                end
            end
            PH_COUNT, PH_LEN:
            begin
                acc_next = acc_digit(cur_acc, digit_val);
            end
            PH_SEPA:
            begin
                if (data_byte == CH_DOLLAR)
                begin
                    phase_next = PH_LEN;
                    acc_next   = '0;
                end
                else if (!is_crlf)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_SEPB:
            begin
                if (!is_crlf)
                begin
                    if (eval_remain == '0 && !is_last_elem)
                    begin
                        if (data_byte == CH_DOLLAR)
                        begin
                            phase_next = PH_LEN;
                            acc_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                        elem_next = cur_elem + 1'b1;
                    end
                    else if (is_last_elem)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        remain_next = eval_remain - 1'b1;
                        if (eval_remain == LENGTH_BITS'(1))
                        begin
                            phase_next = PH_SEPA;
                            elem_next  = cur_elem + 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                // Data bytes are counted without looking at their value.
                if (eval_remain != '0)
                    remain_next = eval_remain - 1'b1;
                if (eval_remain <= LENGTH_BITS'(1))
                begin
                    phase_next = PH_SEPA;
                    elem_next  = cur_elem + 1'b1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    // Result for the current byte.
    always_comb
    begin
        res_valid  = 1'b0;
        res.idx    = cur_elem;
        res.off    = cur_offset;
        res.len    = '0;
        res.status = STATUS_FOUND;
        res.last   = 1'b0;

        unique case (eval_phase)
            PH_SEPA:
            begin
                if (data_byte != CH_DOLLAR && !is_crlf)
                begin
                    res_valid  = 1'b1;
                    res.status = STATUS_NO_DOLLAR;
                    res.last   = 1'b1;
                end
            end
            PH_SEPB:
            begin
                if (!is_crlf)
                begin
                    res_valid = 1'b1;
                    if (eval_remain == '0 && !is_last_elem)
                    begin
                        // An empty element whose data start must be the next dollar sign.
                        if (data_byte != CH_DOLLAR)
                        begin
                            res.idx    = cur_elem + 1'b1;
                            res.status = STATUS_NO_DOLLAR;
                            res.last   = 1'b1;
                        end
                    end
                    else
                    begin
                        res.len  = eval_remain;
                        res.last = is_last_elem;
                    end
                end
            end
            PH_WAIT, PH_COUNT, PH_LEN, PH_DATA, PH_DONE:
            begin
                res_valid = 1'b0;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            elem_reg   <= ELEM_CMD;
            count_reg  <= '0;
            acc_reg    <= '0;
            offset_reg <= '0;
            remain_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            elem_reg   <= elem_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            offset_reg <= offset_next;
            remain_reg <= remain_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            result_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign element_index  = result_reg.idx;
    assign start_offset   = START_W'(result_reg.off);
    assign element_length = ELEN_W'(result_reg.len);
    assign status         = result_reg.status;
    assign last           = result_reg.last;

    // An error transaction always closes the message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status == STATUS_NO_DOLLAR) |-> result_reg.last)
        else $error("error result without last flag");

    // After the final result of a message the parser ignores the rest of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && res.last) |=> (phase_reg == PH_DONE))
        else $error("parser not done after last result");

    // A finished message produces no more results until a new one starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DONE && !first_of_message) |-> !res_valid)
        else $error("result produced after message was done");

    // Only the command, key and value indexes are ever reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.idx == ELEM_CMD || result_reg.idx == ELEM_KEY ||
                           result_reg.idx == ELEM_VALUE))
        else $error("element index out of range");

endmodule

`default_nettype wire
